FILE: hdl/midi_chord_generator_defines.svh
// Assertion macros for the chord generator.
// Included by the top level; the assertion bodies refer to its clk and rst.
`ifndef MIDI_CHORD_GENERATOR_DEFINES_SVH
`define MIDI_CHORD_GENERATOR_DEFINES_SVH
`ifndef SYNTH
// A property that is checked outside reset.
`define MCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// A property that is checked during reset as well.
`define MCG_ASSERT_RESET(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCG_ASSERT(lbl, prop, msg)
`define MCG_ASSERT_RESET(lbl, prop, msg)
`endif
`endif

FILE: hdl/mcg_pkg.sv
// Shared types, constants and chord tables for the chord generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package mcg_pkg;

  // Field and working widths.
  localparam int NOTE_W   = 7;
  localparam int VAL_W    = 9;   // signed working width: -12 .. 175 fits
  localparam int KIND_W   = 5;
  localparam int INV_W    = 2;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 3;   // note counts up to seven
  localparam int TRACK_W  = 2;

  localparam int KIND_COUNT     = 17;
  localparam int TABLE_SLOTS    = 5;
  localparam int MAX_INVERSIONS = 3;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic signed [VAL_W-1:0] OCTAVE_V   = 9'sd12;
  localparam logic signed [VAL_W-1:0] NOTE_MAX_V = 9'sd127;
  // Empty slots hold a value above any real note, so they always sort last.
  localparam logic signed [VAL_W-1:0] NOTE_SENTINEL = 9'sd255;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_KINDS     = 2'd1;
  localparam logic [1:0] REG_INVERSION = 2'd2;
  localparam logic [1:0] REG_VOICING   = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    VOICE_CLOSE  = 2'd0,
    VOICE_DROP2  = 2'd1,
    VOICE_DROP3  = 2'd2,
    VOICE_SPREAD = 2'd3
  } voicing_t;

  // What travels with each chord between the front end and the back end.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    voicing_t           mode;
  } chord_ctl_t;

  localparam logic [4:0] INTERVAL_TABLE [KIND_COUNT][TABLE_SLOTS] = '{
    '{5'd0, 5'd4, 5'd7, 5'd0, 5'd0},   '{5'd0, 5'd3, 5'd7, 5'd0, 5'd0},
    '{5'd0, 5'd3, 5'd6, 5'd0, 5'd0},   '{5'd0, 5'd4, 5'd8, 5'd0, 5'd0},
    '{5'd0, 5'd2, 5'd7, 5'd0, 5'd0},   '{5'd0, 5'd5, 5'd7, 5'd0, 5'd0},
    '{5'd0, 5'd4, 5'd7, 5'd11, 5'd0},  '{5'd0, 5'd3, 5'd7, 5'd10, 5'd0},
    '{5'd0, 5'd4, 5'd7, 5'd10, 5'd0},  '{5'd0, 5'd3, 5'd6, 5'd9, 5'd0},
    '{5'd0, 5'd3, 5'd6, 5'd10, 5'd0},  '{5'd0, 5'd4, 5'd8, 5'd10, 5'd0},
    '{5'd0, 5'd4, 5'd7, 5'd11, 5'd14}, '{5'd0, 5'd3, 5'd7, 5'd10, 5'd14},
    '{5'd0, 5'd4, 5'd7, 5'd10, 5'd14}, '{5'd0, 5'd7, 5'd12, 5'd0, 5'd0},
    '{5'd0, 5'd12, 5'd24, 5'd0, 5'd0}
  };

  localparam logic [COUNT_W-1:0] SIZE_TABLE [KIND_COUNT] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd3, 3'd3
  };

  // Interval of one slot of a chord kind; zero outside the table.
  function automatic logic [4:0] chord_interval(input logic [KIND_W-1:0] kind,
                                                input int slot);
    logic [4:0] result;
    result = 5'd0;
    if (kind < KIND_W'(KIND_COUNT) && slot < TABLE_SLOTS) begin
      result = INTERVAL_TABLE[kind][slot];
    end
    return result;
  endfunction

  // Number of notes of a chord kind; zero for a kind outside the table.
  function automatic logic [COUNT_W-1:0] chord_size(input logic [KIND_W-1:0] kind);
    logic [COUNT_W-1:0] result;
    result = '0;
    if (kind < KIND_W'(KIND_COUNT)) begin
      result = SIZE_TABLE[kind];
    end
    return result;
  endfunction

endpackage

FILE: hdl/mcg_front.sv
// Front end: configuration registers, classification, chord build and inversions.
// Depends on mcg_pkg; feeds the chord queue.
`timescale 1ns / 1ps
module mcg_front import mcg_pkg::*; #(
  parameter int TRACKS    = 4,
  parameter int MAX_NOTES = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [TRACK_W-1:0]             track,
  input  logic [NOTE_W-1:0]              base_note,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [KIND_W*TRACKS-1:0]       cfg_data,
  input  logic                           q_full,
  output logic                           q_write,
  output logic signed [VAL_W-1:0]        q_notes [MAX_NOTES],
  output chord_ctl_t                     q_ctl
);

  logic [TRACKS-1:0]        enable_mask;
  logic [KIND_W*TRACKS-1:0] chord_kinds;
  logic [INV_W*TRACKS-1:0]  inversion_counts;
  logic [MODE_W*TRACKS-1:0] voicing_modes;

  // Held chord, built but not yet inverted.
  logic                     held;
  logic signed [VAL_W-1:0]  held_notes [MAX_NOTES];
  logic [COUNT_W-1:0]       held_count;
  logic [INV_W-1:0]         held_inv;
  voicing_t                 held_mode;

  logic [TRACKS-1:0]        en_sh;
  logic [KIND_W*TRACKS-1:0] kinds_sh;
  logic [INV_W*TRACKS-1:0]  inv_sh;
  logic [MODE_W*TRACKS-1:0] mode_sh;
  logic [KIND_W-1:0]        kind;
  logic                     passthrough;
  logic [COUNT_W-1:0]       size_sel;
  logic signed [VAL_W-1:0]  build_val;
  logic                     build_keep;
  logic signed [VAL_W-1:0]  build_notes [MAX_NOTES];
  logic [COUNT_W-1:0]       build_count;
  logic [INV_W-1:0]         build_inv;
  voicing_t                 build_mode;
  logic                     accept;

  logic signed [VAL_W-1:0]  stg [MAX_INVERSIONS+1][MAX_NOTES];
  logic signed [VAL_W-1:0]  wsh [MAX_NOTES];
  logic signed [VAL_W-1:0]  ins_val;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask      <= '0;
      chord_kinds      <= '0;
      inversion_counts <= '0;
      voicing_modes    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENABLE:    enable_mask      <= cfg_data[TRACKS-1:0];
        REG_KINDS:     chord_kinds      <= cfg_data;
        REG_INVERSION: inversion_counts <= cfg_data[INV_W*TRACKS-1:0];
        REG_VOICING:   voicing_modes    <= cfg_data[MODE_W*TRACKS-1:0];
        default:       ;
      endcase
    end
  end

  // Pick the track's settings and decide whether a chord is built at all.
  always_comb begin
    en_sh    = enable_mask >> int'(track);
    kinds_sh = chord_kinds >> (KIND_W * int'(track));
    inv_sh   = inversion_counts >> (INV_W * int'(track));
    mode_sh  = voicing_modes >> (MODE_W * int'(track));
    kind     = kinds_sh[KIND_W-1:0];
    passthrough = (int'(track) >= TRACKS) || !en_sh[0] ||
                  (kind >= KIND_W'(KIND_COUNT));
    size_sel = passthrough ? COUNT_W'(1) : chord_size(kind);
  end

  // Build the chord. Intervals ascend, so the notes kept form a prefix.
  always_comb begin
    build_count = '0;
    build_val   = '0;
    build_keep  = 1'b0;
    for (int i = 0; i < MAX_NOTES; i++) begin
      build_val = $signed({2'b00, base_note}) +
                  $signed({4'b0000, (passthrough ? 5'd0 : chord_interval(kind, i))});
      build_keep = (COUNT_W'(i) < size_sel) && (build_val <= NOTE_MAX_V);
      build_notes[i] = build_keep ? build_val : NOTE_SENTINEL;
      build_count = build_count + COUNT_W'(build_keep);
    end
    if (passthrough) begin
      build_inv  = '0;
      build_mode = VOICE_CLOSE;
    end else begin
      build_inv  = (COUNT_W'(inv_sh[INV_W-1:0]) >= build_count) ?
                   INV_W'(build_count - COUNT_W'(1)) : inv_sh[INV_W-1:0];
      build_mode = voicing_t'(mode_sh[MODE_W-1:0]);
    end
  end

  assign full    = held && q_full;
  assign accept  = push && !full;
  assign q_write = held && !q_full;

  // Holding register between the input port and the inversion logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (q_write) begin
      held <= 1'b0;
    end
    if (accept) begin
      held_notes <= build_notes;
      held_count <= build_count;
      held_inv   <= build_inv;
      held_mode  <= build_mode;
    end
  end

  // Each inversion takes the lowest note out and inserts it an octave up
  // into the remaining sorted notes.
  always_comb begin
    stg[0]  = held_notes;
    wsh     = held_notes;
    ins_val = '0;
    for (int s = 0; s < MAX_INVERSIONS; s++) begin
      if (s < int'(held_inv)) begin
        for (int k = 0; k < MAX_NOTES - 1; k++) begin
          wsh[k] = stg[s][k+1];
        end
        wsh[MAX_NOTES-1] = NOTE_SENTINEL;
        ins_val = stg[s][0] + OCTAVE_V;
        stg[s+1][0] = (wsh[0] <= ins_val) ? wsh[0] : ins_val;
        for (int k = 1; k < MAX_NOTES; k++) begin
          if (wsh[k] <= ins_val) begin
            stg[s+1][k] = wsh[k];
          end else if (wsh[k-1] <= ins_val) begin
            stg[s+1][k] = ins_val;
          end else begin
            stg[s+1][k] = wsh[k-1];
          end
        end
      end else begin
        stg[s+1] = stg[s];
      end
    end
  end

  assign q_notes     = stg[MAX_INVERSIONS];
  assign q_ctl.count = held_count;
  assign q_ctl.mode  = held_mode;

endmodule

FILE: hdl/mcg_queue.sv
// Short queue of inverted chords between the front end and the back end.
// Depends on mcg_pkg.
`timescale 1ns / 1ps
module mcg_queue import mcg_pkg::*; #(
  parameter int MAX_NOTES = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic signed [VAL_W-1:0] wr_notes [MAX_NOTES],
  input  chord_ctl_t              wr_ctl,
  output logic                    q_full,
  input  logic                    rd_en,
  output logic                    q_valid,
  output logic signed [VAL_W-1:0] rd_notes [MAX_NOTES],
  output chord_ctl_t              rd_ctl
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [VAL_W-1:0] mem_notes [QUEUE_DEPTH][MAX_NOTES];
  chord_ctl_t              mem_ctl   [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [LEVEL_W-1:0]      level;

  assign q_full  = (level == LEVEL_W'(QUEUE_DEPTH));
  assign q_valid = (level != '0);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        level <= level + LEVEL_W'(1);
      end else if (rd_en && !wr_en) begin
        level <= level - LEVEL_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_notes[wr_ptr] <= wr_notes;
      mem_ctl[wr_ptr]   <= wr_ctl;
    end
  end

  assign rd_notes = mem_notes[rd_ptr];
  assign rd_ctl   = mem_ctl[rd_ptr];

endmodule

FILE: hdl/mcg_back.sv
// Back end: voicing, sort and clamp of one chord, then one note word per cycle
// while pop takes them. Depends on mcg_pkg; reads the chord queue.
`timescale 1ns / 1ps
module mcg_back import mcg_pkg::*; #(
  parameter int MAX_NOTES = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  logic signed [VAL_W-1:0] q_notes [MAX_NOTES],
  input  chord_ctl_t              q_ctl,
  output logic                    q_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic [NOTE_W-1:0]       note,
  output logic                    final_note
);

  localparam int IDX_W = $clog2(MAX_NOTES);

  logic signed [VAL_W-1:0] adj  [MAX_NOTES];
  logic signed [VAL_W-1:0] srt  [MAX_NOTES+1][MAX_NOTES];
  logic [NOTE_W-1:0]       clamped [MAX_NOTES];

  // Chord being sent out.
  logic                    work_valid;
  logic [NOTE_W-1:0]       work_notes [MAX_NOTES];
  logic [COUNT_W-1:0]      work_count;
  logic [IDX_W-1:0]        work_idx;

  logic                    out_valid;
  logic                    out_take;
  logic                    emit;
  logic                    last;
  logic                    work_free;

  // Voicing moves at most two notes by an octave.
  always_comb begin
    for (int i = 0; i < MAX_NOTES; i++) begin
      adj[i] = q_notes[i];
      unique case (q_ctl.mode)
        VOICE_CLOSE: ;
        VOICE_DROP2: begin
          if (q_ctl.count >= COUNT_W'(3) && COUNT_W'(i + 2) == q_ctl.count) begin
            adj[i] = q_notes[i] - OCTAVE_V;
          end
        end
        VOICE_DROP3: begin
          if (q_ctl.count >= COUNT_W'(4) && COUNT_W'(i + 3) == q_ctl.count) begin
            adj[i] = q_notes[i] - OCTAVE_V;
          end
        end
        VOICE_SPREAD: begin
          if (q_ctl.count >= COUNT_W'(3) && i >= 2 && ((i & 1) == 0) &&
              COUNT_W'(i) < q_ctl.count) begin
            adj[i] = q_notes[i] + OCTAVE_V;
          end
        end
        default: ;
      endcase
    end
  end

  // Odd-even transposition sort; empty slots stay at the top.
  always_comb begin
    srt[0] = adj;
    for (int r = 0; r < MAX_NOTES; r++) begin
      srt[r+1] = srt[r];
      for (int k = 0; k < MAX_NOTES - 1; k++) begin
        if (((k ^ r) & 1) == 0 && srt[r][k] > srt[r][k+1]) begin
          srt[r+1][k]   = srt[r][k+1];
          srt[r+1][k+1] = srt[r][k];
        end
      end
    end
  end

  // Clamp into the note range.
  always_comb begin
    for (int i = 0; i < MAX_NOTES; i++) begin
      if (srt[MAX_NOTES][i] > NOTE_MAX_V) begin
        clamped[i] = NOTE_W'(NOTE_MAX_V);
      end else if (srt[MAX_NOTES][i] < 0) begin
        clamped[i] = '0;
      end else begin
        clamped[i] = srt[MAX_NOTES][i][NOTE_W-1:0];
      end
    end
  end

  assign out_take  = !out_valid || pop;
  assign emit      = work_valid && out_take;
  assign last      = (COUNT_W'(work_idx) + COUNT_W'(1) == work_count);
  assign work_free = !work_valid || (emit && last);
  assign q_pop     = q_valid && work_free;

  // Load a chord from the queue and step through its notes.
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      work_idx   <= '0;
    end else if (q_pop) begin
      work_valid <= 1'b1;
      work_idx   <= '0;
    end else if (emit && last) begin
      work_valid <= 1'b0;
    end else if (emit) begin
      work_idx <= work_idx + IDX_W'(1);
    end
    if (q_pop) begin
      work_notes <= clamped;
      work_count <= q_ctl.count;
    end
  end

  // Output register, refilled in the cycle its word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      note       <= work_notes[work_idx];
      final_note <= last;
    end
  end

  assign empty = !out_valid;

endmodule

FILE: hdl/midi_chord_generator.sv
// MIDI chord generator: root note in, ascending chord notes out.
// Depends on mcg_pkg, mcg_front, mcg_queue, mcg_back and the defines header.
//
// Input side is a queue: present track and base_note with push; the item is
// taken at a clock edge with push high and full low. Results are a queue
// too: while empty is low, note and final_note carry the oldest note word;
// pop takes it. One root note gives one to five words, lowest note first,
// with final_note set on the last one. Configuration is written through
// cfg_write, cfg_index and cfg_data, by the user only while the block is
// idle; the block itself does not enforce this. An item goes from the
// holding register through the inversion logic into the chord queue, then
// through voicing and sort into the send register, then into the output
// register, which gives one word per cycle while pop takes it. The front
// end keeps accepting new items before a chord is sent, while the holding
// register is free or the two-entry chord queue has room. When pop stays
// low the output holds, the queue fills and full rises. Synchronous reset
// clears the configuration, the valid flags, the queue and the output;
// empty is high and full is low after reset.
`timescale 1ns / 1ps
`include "midi_chord_generator_defines.svh"
module midi_chord_generator import mcg_pkg::*; #(
  parameter int TRACKS    = 4,
  parameter int MAX_NOTES = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [TRACK_W-1:0]       track,
  input  logic [NOTE_W-1:0]        base_note,
  input  logic                     pop,
  output logic                     empty,
  output logic [NOTE_W-1:0]        note,
  output logic                     final_note,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [KIND_W*TRACKS-1:0] cfg_data
);

  logic                    q_write;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;
  logic signed [VAL_W-1:0] wr_notes [MAX_NOTES];
  logic signed [VAL_W-1:0] rd_notes [MAX_NOTES];
  chord_ctl_t              wr_ctl;
  chord_ctl_t              rd_ctl;

  mcg_front #(
    .TRACKS    (TRACKS),
    .MAX_NOTES (MAX_NOTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .track     (track),
    .base_note (base_note),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_write   (q_write),
    .q_notes   (wr_notes),
    .q_ctl     (wr_ctl)
  );

  mcg_queue #(
    .MAX_NOTES (MAX_NOTES)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_write),
    .wr_notes (wr_notes),
    .wr_ctl   (wr_ctl),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .q_valid  (q_valid),
    .rd_notes (rd_notes),
    .rd_ctl   (rd_ctl)
  );

  mcg_back #(
    .MAX_NOTES (MAX_NOTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_notes    (rd_notes),
    .q_ctl      (rd_ctl),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .note       (note),
    .final_note (final_note)
  );

  // Checks on the block's own sequencing.
  `MCG_ASSERT_RESET(a_reset_clears, rst |=> (empty && !full), "reset left a word or a stall")
  `MCG_ASSERT(a_chord_runs_on, (!empty && pop && !final_note) |=> !empty, "chord broke off")
  `MCG_ASSERT(a_full_needs_queue, full |-> (q_full && q_valid), "stall without a full queue")
  `MCG_ASSERT(a_pop_needs_entry, q_pop |-> q_valid, "queue read while empty")

endmodule
